@@ src/ptsp_pkg.sv @@
// shared types and constants of the transport stream packetizer
package ptsp_pkg;

    localparam int unsigned TS_PACKET_BYTES  = 188;
    localparam int unsigned TS_PAYLOAD_BYTES = 184;
    localparam int unsigned PCR_AF_LEN       = 7;
    localparam int unsigned PCR_DIVISOR      = 300;
    localparam int unsigned OFFSET_BITS      = 42;
    localparam int unsigned CFG_IDX_BITS     = 3;

    localparam logic [41:0] PCR_WRAP      = 42'd2576980377600;
    localparam logic [7:0]  SYNC_BYTE     = 8'h47;
    localparam logic [7:0]  STUFF_BYTE    = 8'hff;
    localparam logic [7:0]  PCR_FLAG_BYTE = 8'h10;
    localparam logic [3:0]  CC_RESET      = 4'd1;

    localparam logic [7:0]  SLOT_LAST_P1  = 8'(TS_PACKET_BYTES);
    localparam logic [7:0]  PAY_FULL      = 8'(TS_PAYLOAD_BYTES);
    localparam logic [7:0]  PAY_PCR       = 8'(TS_PAYLOAD_BYTES - 1 - PCR_AF_LEN);
    localparam logic [7:0]  AF_NO_PCR     = 8'(TS_PAYLOAD_BYTES - 1);

    // stream codes
    localparam logic [1:0] STREAM_VIDEO    = 2'd0;
    localparam logic [1:0] STREAM_AUDIO    = 2'd1;
    localparam logic [1:0] STREAM_TELETEXT = 2'd2;
    localparam logic [1:0] STREAM_TABLE    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PID_VIDEO    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PID_AUDIO    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PID_TELETEXT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PID_TABLE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PCR_OFFSET   = 3'd4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [1:0]  stream_select;
        logic        packet_begin;
        logic [19:0] packet_length;
        logic [31:0] packet_dts;
    } t_ts_in;

    typedef struct packed {
        logic [31:0] ts_word;
        logic        ts_packet_end;
        logic        run_last;
        logic        length_error;
    } t_ts_out;

    // one classified input byte, handed from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic [12:0] pid;
        logic        pusi;
        logic        afe;
        logic [3:0]  cc;
        logic [7:0]  aflen;
        logic        with_pcr;
        logic [32:0] base;
        logic [8:0]  ext;
        logic [7:0]  data_slot;
        logic [7:0]  end_slot;
        logic        restart;
        logic        err;
    } t_job;

endpackage

@@ src/pes_to_ts_packetizer_top.sv @@
// pes to transport stream packetizer, top level
// a run's first word passes the job queue, the back end and the output queue before
// it can be popped, and waits longer when the run opens with a header
// the back end lays out one transport byte a cycle while a job is queued and the output
// queue has room; header, adaptation field or table padding bytes come on top of the data
// a write of pcr_offset holds full high while the offset is divided by 300
// synchronous active-low reset restores register defaults and all stream state
module pes_to_ts_packetizer_top import ptsp_pkg::*; #(
    parameter int LENGTH_BITS = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [OFFSET_BITS-1:0]  i_cfg_data,
    input  logic                    push,
    input  t_ts_in                  i_in,
    output logic                    full,
    input  logic                    pop,
    output t_ts_out                 o_out,
    output logic                    empty
);
    logic    job_push, job_full, job_pop, job_empty, out_push, out_full;
    t_job    job_in, job_out;
    t_ts_out back_out;

    ptsp_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_in       (i_in),
        .o_full     (full),
        .o_job_push (job_push),
        .o_job      (job_in),
        .i_job_full (job_full)
    );

    ptsp_fifo #(.WIDTH($bits(t_job)), .DEPTH(4)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    ptsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_out_push  (out_push),
        .o_out       (back_out),
        .i_out_full  (out_full)
    );

    ptsp_fifo #(.WIDTH($bits(t_ts_out)), .DEPTH(4)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_out),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );
endmodule

@@ src/ptsp_fifo.sv @@
// small register queue
module ptsp_fifo import ptsp_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

@@ src/ptsp_div.sv @@
// divide of the pcr offset by 300, one dividend byte a cycle by reciprocal multiply
module ptsp_div import ptsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [OFFSET_BITS-1:0] i_value,
    output logic                   o_busy,
    output logic [32:0]            o_quot,
    output logic [8:0]             o_rem
);
    localparam int          NUM_BITS = 48;
    // ceil(2^25 / 300), exact for every partial dividend below 300 * 256
    localparam logic [16:0] RECIP    = 17'd111849;

    logic [NUM_BITS-1:0] r_num, n_num;
    logic [8:0]          r_part, n_part;
    logic [2:0]          r_cnt;
    logic                r_busy;
    logic [16:0]         trial;
    logic [33:0]         prod;
    logic [7:0]          qd;

    assign trial  = {r_part, r_num[NUM_BITS-1 -: 8]};
    assign prod   = 34'(trial) * 34'(RECIP);
    assign qd     = prod[32:25];
    assign n_part = 9'(trial - 17'(qd) * 17'(PCR_DIVISOR));
    assign n_num  = {r_num[NUM_BITS-9:0], qd};

    assign o_busy = r_busy;
    assign o_quot = r_num[32:0];
    assign o_rem  = r_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num  <= '0;
            r_part <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_num  <= NUM_BITS'(i_value);
            r_part <= '0;
            r_cnt  <= 3'd6;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            r_num  <= n_num;
            r_part <= n_part;
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != 3'd1);
        end
    end
endmodule

@@ src/ptsp_front.sv @@
// input side: config registers, stream state and classification of each byte
module ptsp_front import ptsp_pkg::*; #(
    parameter int LENGTH_BITS = 20
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [OFFSET_BITS-1:0]  i_cfg_data,
    input  logic                    i_push,
    input  t_ts_in                  i_in,
    output logic                    o_full,
    output logic                    o_job_push,
    output t_job                    o_job,
    input  logic                    i_job_full
);
    localparam logic [31:0] MAXLEN = 32'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [12:0]            r_pid [4];
    logic [3:0]             r_cc  [4];
    logic [31:0]            r_last_dts;
    logic [LENGTH_BITS-1:0] r_rem;
    logic [7:0]             r_slot;
    logic [1:0]             r_stream;
    logic                   r_first;

    logic                   div_load, div_busy;
    logic [OFFSET_BITS-1:0] off_red;
    logic [32:0]            quot;
    logic [8:0]             rmd;

    logic                   begin_b, accept, active, restart, err, hdr, stuff, afe, with_pcr, pad;
    logic [LENGTH_BITS-1:0] len_v, rem, rem_n;
    logic [1:0]             stream;
    logic                   first;
    logic [7:0]             slot_f, aflen, hlen, data_slot, slot_p1;

    // offset taken modulo the pcr wrap before the divide
    assign off_red  = (i_cfg_data >= PCR_WRAP) ? i_cfg_data - PCR_WRAP : i_cfg_data;
    assign div_load = i_cfg_we && (i_cfg_idx == CFG_PCR_OFFSET);

    ptsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (div_load),
        .i_value (off_red),
        .o_busy  (div_busy),
        .o_quot  (quot),
        .o_rem   (rmd)
    );

    assign o_full  = i_job_full || div_busy;
    assign accept  = i_push && !o_full;
    assign begin_b = i_in.packet_begin;

    always_comb begin
        err     = 1'b0;
        restart = 1'b0;
        len_v   = LENGTH_BITS'(i_in.packet_length);
        if (begin_b) begin
            if (r_rem != '0) begin
                err     = 1'b1;
                restart = 1'b1;
            end
            if (i_in.packet_length == '0) begin
                len_v = LENGTH_BITS'(1);
                err   = 1'b1;
            end else if (32'(i_in.packet_length) > MAXLEN) begin
                len_v = LENGTH_BITS'(MAXLEN);
                err   = 1'b1;
            end
        end
        rem      = begin_b ? len_v : r_rem;
        stream   = begin_b ? i_in.stream_select : r_stream;
        first    = begin_b ? 1'b1 : r_first;
        active   = begin_b || (r_rem != '0);
        slot_f   = restart ? 8'd0 : r_slot;
        hdr      = (slot_f == 8'd0);
        with_pcr = begin_b && (i_in.stream_select == STREAM_VIDEO) && (r_last_dts != '0);

        stuff = (rem < LENGTH_BITS'(with_pcr ? PAY_PCR : PAY_FULL)) && (stream != STREAM_TABLE);
        if (with_pcr) begin
            aflen = 8'(PCR_AF_LEN) + (stuff ? PAY_PCR - rem[7:0] : 8'd0);
        end else begin
            aflen = stuff ? AF_NO_PCR - rem[7:0] : 8'd0;
        end
        afe = with_pcr || stuff;

        hlen      = hdr ? (afe ? 8'd5 + aflen : 8'd4) : 8'd0;
        data_slot = slot_f + hlen;
        slot_p1   = data_slot + 8'd1;
        rem_n     = rem - 1'b1;
        pad       = (rem_n == '0);

        o_job.data      = i_in.data_byte;
        o_job.pid       = r_pid[stream];
        o_job.pusi      = first;
        o_job.afe       = afe;
        o_job.cc        = r_cc[stream];
        o_job.aflen     = aflen;
        o_job.with_pcr  = with_pcr;
        // dts*600 is an exact multiple of 300, so base and extension come
        // straight from the quotient and remainder of the offset
        o_job.base      = {r_last_dts, 1'b0} - quot - 33'(rmd != '0);
        o_job.ext       = (rmd == '0) ? 9'd0 : 9'(PCR_DIVISOR) - rmd;
        o_job.data_slot = data_slot;
        o_job.end_slot  = pad ? SLOT_LAST_P1 : slot_p1;
        o_job.restart   = restart;
        o_job.err       = err;
    end

    assign o_job_push = accept && active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid[STREAM_VIDEO]    <= 13'd100;
            r_pid[STREAM_AUDIO]    <= 13'd101;
            r_pid[STREAM_TELETEXT] <= 13'd102;
            r_pid[STREAM_TABLE]    <= 13'd18;
            for (int i = 0; i < 4; i++) begin
                r_cc[i] <= CC_RESET;
            end
            r_last_dts <= '0;
            r_rem      <= '0;
            r_slot     <= '0;
            r_stream   <= '0;
            r_first    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PID_VIDEO:    r_pid[STREAM_VIDEO]    <= i_cfg_data[12:0];
                    CFG_PID_AUDIO:    r_pid[STREAM_AUDIO]    <= i_cfg_data[12:0];
                    CFG_PID_TELETEXT: r_pid[STREAM_TELETEXT] <= i_cfg_data[12:0];
                    CFG_PID_TABLE:    r_pid[STREAM_TABLE]    <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (begin_b) begin
                    r_stream <= i_in.stream_select;
                    if (i_in.stream_select == STREAM_VIDEO) begin
                        r_last_dts <= i_in.packet_dts;
                    end
                end
                if (active) begin
                    r_rem   <= rem_n;
                    r_first <= hdr ? 1'b0 : first;
                    r_slot  <= (pad || slot_p1 == SLOT_LAST_P1) ? 8'd0 : slot_p1;
                    if (hdr) begin
                        r_cc[stream] <= r_cc[stream] + 1'b1;
                    end
                end
            end
        end
    end
endmodule

@@ src/ptsp_back.sv @@
// output: header, adaptation field, data, padding; one byte a cycle unless stalled
module ptsp_back import ptsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_job    i_job,
    input  logic    i_job_empty,
    output logic    o_job_pop,
    output logic    o_out_push,
    output t_ts_out o_out,
    input  logic    i_out_full
);
    logic [7:0]  r_slot;
    logic [31:0] r_asm;
    logic        r_mid;

    logic        step, fresh, word_done, job_done;
    logic [7:0]  s, n_slot, b, pfx;
    logic [31:0] cur_asm, n_asm;

    assign step  = !i_job_empty && !i_out_full;
    // an early packet begin drops the unfinished packet and partial word
    assign fresh = i_job.restart && !r_mid;

    always_comb begin
        s       = fresh ? 8'd0 : r_slot;
        cur_asm = fresh ? 32'd0 : r_asm;
        case (s)
            8'd0:  pfx = SYNC_BYTE;
            8'd1:  pfx = {1'b0, i_job.pusi, 1'b0, i_job.pid[12:8]};
            8'd2:  pfx = i_job.pid[7:0];
            8'd3:  pfx = {2'b00, i_job.afe, 1'b1, i_job.cc};
            8'd4:  pfx = i_job.aflen;
            8'd5:  pfx = i_job.with_pcr ? PCR_FLAG_BYTE : 8'h00;
            8'd6:  pfx = i_job.with_pcr ? i_job.base[32:25] : STUFF_BYTE;
            8'd7:  pfx = i_job.with_pcr ? i_job.base[24:17] : STUFF_BYTE;
            8'd8:  pfx = i_job.with_pcr ? i_job.base[16:9] : STUFF_BYTE;
            8'd9:  pfx = i_job.with_pcr ? i_job.base[8:1] : STUFF_BYTE;
            8'd10: pfx = i_job.with_pcr ? {i_job.base[0], 6'b111111, i_job.ext[8]}
                                        : STUFF_BYTE;
            8'd11: pfx = i_job.with_pcr ? i_job.ext[7:0] : STUFF_BYTE;
            default: pfx = STUFF_BYTE;
        endcase
        if (s < i_job.data_slot) begin
            b = pfx;
        end else if (s == i_job.data_slot) begin
            b = i_job.data;
        end else begin
            b = STUFF_BYTE;
        end
        n_asm     = {cur_asm[23:0], b};
        n_slot    = s + 8'd1;
        word_done = (n_slot[1:0] == 2'b00);
        job_done  = (n_slot == i_job.end_slot);

        o_out.ts_word       = n_asm;
        o_out.ts_packet_end = (n_slot == SLOT_LAST_P1);
        // last beat of the run when no later word boundary falls inside the job
        o_out.run_last      = (i_job.end_slot[7:2] == n_slot[7:2]);
        o_out.length_error  = i_job.err;
    end

    assign o_out_push = step && word_done;
    assign o_job_pop  = step && job_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_asm  <= '0;
            r_mid  <= 1'b0;
        end else if (step) begin
            r_slot <= (n_slot == SLOT_LAST_P1) ? 8'd0 : n_slot;
            r_asm  <= word_done ? 32'd0 : n_asm;
            r_mid  <= !job_done;
        end
    end
endmodule

@@ test/ts_packetizer_checker.sv @@
// checker for the transport stream packetizer: predicts words and compares
`timescale 1ns / 1ps
module ts_packetizer_checker import ptsp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [OFFSET_BITS-1:0]  i_cfg_data,
    input  logic                    i_push,
    input  t_ts_in                  i_in,
    input  logic                    i_full,
    input  logic                    i_pop,
    input  t_ts_out                 i_out,
    input  logic                    i_empty,
    output int                      o_errors,
    output int                      o_pending,
    output int                      o_words_seen
);

    logic [12:0] pid_tab [4];
    logic [41:0] offset_reg;
    logic [3:0]  cc_tab [4];
    logic [31:0] prev_video_dts;
    logic [19:0] bytes_left;
    int unsigned slot;
    logic [31:0] word_acc;
    logic [1:0]  cur_stream;
    logic        first_chunk;

    t_ts_out expected_words [$];
    t_ts_out run_words [$];
    logic    run_err;

    function automatic void put_byte(logic [7:0] b);
        t_ts_out w;
        word_acc = {word_acc[23:0], b};
        slot++;
        if (slot % 4 == 0) begin
            w.ts_word = word_acc;
            w.ts_packet_end = (slot >= TS_PACKET_BYTES);
            w.run_last = 1'b0;
            w.length_error = run_err;
            run_words.push_back(w);
            word_acc = '0;
        end
        if (slot >= TS_PACKET_BYTES) slot = 0;
    endfunction

    function automatic void put_header(logic with_pcr, logic [41:0] pcr);
        int unsigned room, aflen, used;
        logic        afe;
        logic [12:0] pid;
        logic [3:0]  cc;
        logic [32:0] base;
        logic [8:0]  ext;
        room = TS_PAYLOAD_BYTES;
        afe = with_pcr;
        aflen = 0;
        if (with_pcr) begin
            aflen = PCR_AF_LEN;
            room = TS_PAYLOAD_BYTES - 1 - PCR_AF_LEN;
        end
        if (bytes_left < room && cur_stream != STREAM_TABLE) begin
            if (afe) aflen += room - bytes_left;
            else begin
                afe = 1'b1;
                aflen = TS_PAYLOAD_BYTES - 1 - bytes_left;
            end
        end
        pid = pid_tab[cur_stream];
        cc = cc_tab[cur_stream];
        cc_tab[cur_stream] = cc + 4'd1;
        put_byte(SYNC_BYTE);
        put_byte({1'b0, first_chunk, 1'b0, pid[12:8]});
        put_byte(pid[7:0]);
        put_byte({2'b00, afe, 1'b1, cc});
        first_chunk = 1'b0;
        if (!afe) return;
        put_byte(8'(aflen));
        if (aflen == 0) return;
        put_byte(with_pcr ? PCR_FLAG_BYTE : 8'h00);
        used = 1;
        if (with_pcr) begin
            base = 33'(pcr / 300);
            ext = 9'(pcr % 300);
            put_byte(base[32:25]);
            put_byte(base[24:17]);
            put_byte(base[16:9]);
            put_byte(base[8:1]);
            put_byte({base[0], 6'h3f, ext[8]});
            put_byte(ext[7:0]);
            used += 6;
        end
        for (int unsigned k = used; k < aflen; k++) put_byte(STUFF_BYTE);
    endfunction

    function automatic void predict_byte(t_ts_in it);
        logic        with_pcr;
        logic [41:0] pcr, prod, off;
        logic [19:0] len;
        with_pcr = 1'b0;
        pcr = '0;
        run_err = 1'b0;
        run_words.delete();
        if (it.packet_begin) begin
            len = it.packet_length;
            if (bytes_left != 0) begin
                run_err = 1'b1;
                slot = 0;
                word_acc = '0;
            end
            if (len == 0) begin
                len = 1;
                run_err = 1'b1;
            end
            bytes_left = len;
            cur_stream = it.stream_select;
            first_chunk = 1'b1;
            if (it.stream_select == STREAM_VIDEO) begin
                if (prev_video_dts != 0) begin
                    prod = 42'(prev_video_dts) * 42'd600;
                    off = offset_reg % PCR_WRAP;
                    with_pcr = 1'b1;
                    pcr = (prod >= off) ? prod - off : prod + PCR_WRAP - off;
                end
                prev_video_dts = it.packet_dts;
            end
        end
        if (bytes_left == 0) return;
        if (slot == 0) put_header(with_pcr, pcr);
        put_byte(it.data_byte);
        bytes_left--;
        if (bytes_left == 0) while (slot != 0) put_byte(STUFF_BYTE);
        if (run_words.size() > 0) run_words[run_words.size()-1].run_last = 1'b1;
        foreach (run_words[k]) expected_words.push_back(run_words[k]);
    endfunction

    assign o_pending = expected_words.size();

    always @(posedge i_clk) begin
        t_ts_out exp_w;
        if (!i_rst_n) begin
            pid_tab[0] = 13'd100;
            pid_tab[1] = 13'd101;
            pid_tab[2] = 13'd102;
            pid_tab[3] = 13'd18;
            offset_reg = '0;
            for (int k = 0; k < 4; k++) cc_tab[k] = CC_RESET;
            prev_video_dts = '0;
            bytes_left = '0;
            slot = 0;
            word_acc = '0;
            cur_stream = STREAM_VIDEO;
            first_chunk = 1'b0;
            expected_words.delete();
            o_errors <= 0;
            o_words_seen <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PID_VIDEO:    pid_tab[0] = i_cfg_data[12:0];
                    CFG_PID_AUDIO:    pid_tab[1] = i_cfg_data[12:0];
                    CFG_PID_TELETEXT: pid_tab[2] = i_cfg_data[12:0];
                    CFG_PID_TABLE:    pid_tab[3] = i_cfg_data[12:0];
                    CFG_PCR_OFFSET:   offset_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) predict_byte(i_in);
            if (i_pop && !i_empty) begin
                o_words_seen <= o_words_seen + 1;
                if (expected_words.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected beat: got %h/%b%b%b", i_out.ts_word,
                                 i_out.ts_packet_end, i_out.run_last, i_out.length_error);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w !== i_out) begin
                        if (o_errors < 10)
                            $display("beat mismatch: exp %h end %b last %b err %b, got %h end %b last %b err %b",
                                     exp_w.ts_word, exp_w.ts_packet_end, exp_w.run_last,
                                     exp_w.length_error, i_out.ts_word, i_out.ts_packet_end,
                                     i_out.run_last, i_out.length_error);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

@@ test/tb_top.sv @@
// testbench top for the transport stream packetizer: stimulus and verdict
`timescale 1ns / 1ps
module tb_top import ptsp_pkg::*;;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [OFFSET_BITS-1:0]  i_cfg_data = '0;
    logic                    push = 1'b0;
    t_ts_in                  i_in = '0;
    logic                    full;
    logic                    pop = 1'b0;
    t_ts_out                 o_out;
    logic                    empty;
    int                      errors, pending, words_seen;
    int                      idle_cycles = 0;
    int                      bytes_sent = 0;
    int                      packets_sent = 0;
    bit                      hold_sink = 1'b0;
    bit                      stim_done = 1'b0;

    localparam int WATCHDOG_LIMIT = 20000;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pes_to_ts_packetizer_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .push(push), .i_in(i_in), .full(full), .pop(pop),
        .o_out(o_out), .empty(empty)
    );

    ts_packetizer_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_push(push), .i_in(i_in), .i_full(full), .i_pop(pop),
        .i_out(o_out), .i_empty(empty), .o_errors(errors), .o_pending(pending),
        .o_words_seen(words_seen)
    );

    // one byte beat; waits until accepted
    task automatic send_byte(logic [7:0] b, logic [1:0] s, logic beg, logic [19:0] len,
                             logic [31:0] dts, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 6) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= '{data_byte: b, stream_select: s, packet_begin: beg,
                  packet_length: len, packet_dts: dts};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    // a pes packet of given length; cut shortens it to test early begin
    task automatic send_packet(logic [1:0] s, int len, int cut, logic [31:0] dts, bit gaps);
        for (int k = 0; k < len - cut; k++)
            send_byte(8'($urandom), s, k == 0, 20'(len), dts, gaps);
        packets_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [OFFSET_BITS-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain;
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // offset write holds the block busy for its division
        repeat (60) @(posedge i_clk);
    endtask

    // sink side: random wait before each beat, plus long hold-offs on request
    initial begin
        int wait_n;
        @(posedge i_clk);
        forever begin
            wait_n = stim_done ? 0 : $urandom_range(0, 6);
            if (wait_n > 0 || hold_sink) begin
                pop <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
                while (hold_sink) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int len;
        int target;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each stream, short lengths, stray byte, zero length, early begin
        send_byte(8'hff, STREAM_AUDIO, 1'b0, 20'd0, 32'd0, 1'b0);
        send_packet(STREAM_VIDEO, 3, 0, 32'hffff_ffff, 1'b0);
        send_packet(STREAM_VIDEO, 2, 0, 32'd1, 1'b0);
        send_packet(STREAM_AUDIO, 1, 0, 32'd0, 1'b0);
        send_packet(STREAM_TELETEXT, 4, 0, 32'd0, 1'b0);
        send_packet(STREAM_TABLE, 5, 0, 32'd0, 1'b0);
        send_byte(8'h00, STREAM_TABLE, 1'b1, 20'd0, 32'd0, 1'b0);
        send_byte(8'h5a, STREAM_AUDIO, 1'b1, 20'hfffff, 32'd0, 1'b0);
        send_byte(8'ha5, STREAM_AUDIO, 1'b0, 20'd0, 32'd0, 1'b0);
        send_packet(STREAM_VIDEO, 4, 0, 32'd0, 1'b0);
        send_packet(STREAM_VIDEO, 2, 0, 32'd7, 1'b0);
        drain();

        write_reg(CFG_PID_VIDEO, 42'h1fff);
        write_reg(CFG_PID_AUDIO, 42'h0);
        write_reg(CFG_PID_TELETEXT, 42'h0aaa);
        write_reg(CFG_PID_TABLE, 42'h1555);
        write_reg(CFG_PCR_OFFSET, 42'h3ff_ffff_ffff);

        // long receiver hold-off while a two-chunk video packet with pcr keeps coming
        hold_sink = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            send_packet(STREAM_VIDEO, 177, 0, 32'hffff_ffff, 1'b0);
        join
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            write_reg(CFG_PID_VIDEO, 42'($urandom_range(0, 8191)));
            write_reg(CFG_PID_AUDIO, 42'($urandom_range(0, 8191)));
            write_reg(CFG_PID_TELETEXT, 42'($urandom_range(0, 8191)));
            write_reg(CFG_PID_TABLE, 42'($urandom_range(0, 8191)));
            write_reg(CFG_PCR_OFFSET, phase == 0 ? 42'd0 :
                      {10'($urandom), 32'($urandom)});
            target = bytes_sent + 22;
            while (bytes_sent < target) begin
                len = $urandom_range(1, 24);
                if ($urandom_range(0, 15) == 0)
                    send_byte(8'($urandom), 2'($urandom), 1'b0, 20'($urandom),
                              $urandom, 1'b1);
                send_packet(2'($urandom), len,
                            ($urandom_range(0, 7) == 0 && len > 1) ? 1 : 0,
                            ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom, 1'b1);
            end
            drain();
        end

        stim_done = 1'b1;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("run covered %0d pes bytes in %0d packets, %0d transport words",
                 bytes_sent, packets_sent, words_seen);
        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule
